// ===== hw/rtl/kpq_pkg.sv =====
// Package for the keyed priority queue: field widths, command and cell operation codes,
// and the packed structs for the request, response and cell entries.
// No dependencies.
package kpq_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 64;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_RANGE  = 2'd2,
        CMD_IGNORE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_UPDATE,
        OP_INSERT,
        OP_SHIFT,
        OP_MARK,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RANGE
    } state_t;

    typedef struct packed {
        cmd_t                  command;
        logic [KEY_BITS-1:0]   item_key;
        logic [VALUE_BITS-1:0] item_value;
        logic [KEY_BITS-1:0]   range_low;
        logic [KEY_BITS-1:0]   range_high;
    } req_t;

    typedef struct packed {
        logic                  ok;
        logic [KEY_BITS-1:0]   out_key;
        logic [VALUE_BITS-1:0] out_value;
        logic                  last;
    } rsp_t;

    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef struct packed {
        cell_op_t              op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [KEY_BITS-1:0]   lo;
        logic [KEY_BITS-1:0]   hi;
    } cell_ctl_t;

    typedef struct packed {
        logic gt;
        logic match;
        logic hit_now;
    } cell_stat_t;

endpackage

// ===== hw/rtl/kpq_cell.sv =====
// One cell of the sorted chain: holds one key/value entry with its valid and range-hit flags.
// Depends on kpq_pkg.
module kpq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  kpq_pkg::cell_ctl_t ctl,
    input  kpq_pkg::entry_t    prv_entry,
    input  logic               prv_gt,
    input  kpq_pkg::entry_t    nxt_entry,
    output kpq_pkg::entry_t    entry,
    output kpq_pkg::cell_stat_t stat
);
    import kpq_pkg::*;

    logic                  valid_reg, valid_next;
    logic                  hit_reg, hit_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    always_comb
    begin
        stat.gt      = valid_reg && (key_reg > ctl.key);
        stat.match   = valid_reg && (key_reg == ctl.key);
        stat.hit_now = valid_reg && (key_reg >= ctl.lo) && (key_reg <= ctl.hi);
    end

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        key_next   = key_reg;
        value_next = value_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
            end
            OP_UPDATE:
            begin
                if (stat.match)
                begin
                    value_next = ctl.value;
                end
            end
            OP_INSERT:
            begin
                if (!stat.gt)
                begin
                    if (prv_gt)
                    begin
                        valid_next = 1'b1;
                        hit_next   = 1'b0;
                        key_next   = ctl.key;
                        value_next = ctl.value;
                    end
                    else
                    begin
                        valid_next = prv_entry.valid;
                        hit_next   = 1'b0;
                        key_next   = prv_entry.key;
                        value_next = prv_entry.value;
                    end
                end
            end
            OP_SHIFT, OP_ROTATE:
            begin
                valid_next = nxt_entry.valid;
                hit_next   = nxt_entry.hit;
                key_next   = nxt_entry.key;
                value_next = nxt_entry.value;
            end
            OP_MARK:
            begin
                hit_next = stat.hit_now;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.hit   = hit_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule

// ===== hw/rtl/keyed_priority_queue_unit.sv =====
// Top level of the keyed priority queue: a chain of kpq_cell instances, the control FSM
// and the response register. Depends on kpq_pkg and kpq_cell.
//
// Requests arrive on req (valid/ready) and responses leave on rsp (valid/ready).
// The store holds up to CAPACITY entries kept in descending key order, one per cell.
// An enqueue or dequeue is a single transfer in and a single transfer out: the chain
// updates in the cycle the request is taken and the response appears in the next cycle.
// A new enqueue or dequeue can be taken every cycle while idle and the receiver keeps up.
// A range query marks matching cells in the cycle it is taken, then rotates the whole
// chain once around through cell 0, emitting one response per matching entry in
// descending key order, the last one flagged. Req ready stays low during the rotation.
// A query with no match gives one failing response and the block stays idle.
// When the receiver stalls, the response register holds its transfer and the rotation
// pauses at the next matching entry; no request is taken while the register is full
// and not being drained. Reset empties the store and the response register.
module keyed_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  kpq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output kpq_pkg::rsp_t rsp
);
    import kpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    entry_t     entries [CAPACITY];
    cell_stat_t stats   [CAPACITY];
    entry_t     prv_entries [CAPACITY];
    entry_t     nxt_entries [CAPACITY];
    logic       prv_gts [CAPACITY];
    logic [CAPACITY-1:0] match_vec, hit_now_vec, hit_vec;

    cell_ctl_t  ctl;
    state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;
    logic       rsp_load;
    rsp_t       rsp_load_item;
    logic       accept, stall, any_match, full;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign prv_entries[gi] = '0;
                assign prv_gts[gi]     = 1'b1;
            end
            else
            begin : g_rest
                assign prv_entries[gi] = entries[gi-1];
                assign prv_gts[gi]     = stats[gi-1].gt;
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign nxt_entries[gi] = (ctl.op == OP_ROTATE)
                    ? {entries[0].valid, 1'b0, entries[0].key, entries[0].value} : '0;
            end
            else
            begin : g_body
                assign nxt_entries[gi] = entries[gi+1];
            end

            assign match_vec[gi]   = stats[gi].match;
            assign hit_now_vec[gi] = stats[gi].hit_now;
            assign hit_vec[gi]     = entries[gi].hit;

            kpq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .prv_entry (prv_entries[gi]),
                .prv_gt    (prv_gts[gi]),
                .nxt_entry (nxt_entries[gi]),
                .entry     (entries[gi]),
                .stat      (stats[gi])
            );
        end
    endgenerate

    assign any_match = |match_vec;
    assign full      = entries[CAPACITY-1].valid;
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign stall     = entries[0].hit && rsp_valid_reg && !rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.command == CMD_RANGE) && (|hit_now_vec))
                begin
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                if (!stall && (cnt_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.op        = OP_HOLD;
        ctl.key       = req.item_key;
        ctl.value     = req.item_value;
        ctl.lo        = req.range_low;
        ctl.hi        = req.range_high;
        rsp_load      = 1'b0;
        rsp_load_item = '0;
        cnt_next      = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.command)
                        CMD_ENQ:
                        begin
                            if (any_match)
                            begin
                                ctl.op = OP_UPDATE;
                            end
                            else if (!full)
                            begin
                                ctl.op = OP_INSERT;
                            end
                            rsp_load                = 1'b1;
                            rsp_load_item.ok        = any_match || !full;
                            rsp_load_item.out_key   = req.item_key;
                            rsp_load_item.out_value = req.item_value;
                            rsp_load_item.last      = 1'b1;
                        end
                        CMD_DEQ:
                        begin
                            rsp_load           = 1'b1;
                            rsp_load_item.last = 1'b1;
                            if (entries[0].valid)
                            begin
                                ctl.op                  = OP_SHIFT;
                                rsp_load_item.ok        = 1'b1;
                                rsp_load_item.out_key   = entries[0].key;
                                rsp_load_item.out_value = entries[0].value;
                            end
                        end
                        CMD_RANGE:
                        begin
                            ctl.op   = OP_MARK;
                            cnt_next = CNT_W'(CAPACITY);
                            if (!(|hit_now_vec))
                            begin
                                rsp_load           = 1'b1;
                                rsp_load_item.last = 1'b1;
                            end
                        end
                        CMD_IGNORE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RANGE:
            begin
                if (!stall)
                begin
                    ctl.op   = OP_ROTATE;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (entries[0].hit)
                    begin
                        rsp_load                = 1'b1;
                        rsp_load_item.ok        = 1'b1;
                        rsp_load_item.out_key   = entries[0].key;
                        rsp_load_item.out_value = entries[0].value;
                        rsp_load_item.last      = !(|hit_vec[CAPACITY-1:1]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = rsp_load_item;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/kpq_checker.sv =====
// Port-level checker for keyed_priority_queue_unit, attached by the bind at the end.
// Depends on kpq_pkg.
module kpq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input kpq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input kpq_pkg::rsp_t rsp
);
    import kpq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Stalled response transfer changed.");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.last)
        else $error("Failing response not marked last.");

    a_ignore_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.command == CMD_IGNORE) |=> !rsp_valid)
        else $error("Unused command produced a response.");

    a_enq_echo: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.command == CMD_ENQ) |=>
        rsp_valid && rsp.last && (rsp.out_key == $past(req.item_key))
        && (rsp.out_value == $past(req.item_value)))
        else $error("Enqueue response does not echo the request.");

endmodule

bind keyed_priority_queue_unit kpq_checker u_kpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/tb_keyed_priority_queue_unit.sv =====
// Self-checking testbench for keyed_priority_queue_unit: a sorted key/value store model
// predicts every response of enqueue, dequeue and range requests under random idling.
// Depends on kpq_pkg and keyed_priority_queue_unit.
module tb_keyed_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import kpq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int HOLD_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic [KEY_BITS-1:0] store_key [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] store_val [QUEUE_DEPTH];
    int store_count = 0;
    rsp_t expected_rsp_q[$];

    int req_idle_pct = 27;
    int rsp_stall_pct = 27;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    int mismatches = 0;
    int requests_sent = 0;
    int responses_checked = 0;
    int key_updates = 0;
    int full_rejects = 0;
    int longest_range = 0;

    keyed_priority_queue_unit #(
        .CAPACITY(QUEUE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic req_t make_req(cmd_t cmd, logic [KEY_BITS-1:0] key,
                                      logic [VALUE_BITS-1:0] value,
                                      logic [KEY_BITS-1:0] lo, logic [KEY_BITS-1:0] hi);
        req_t r;
        r.command = cmd;
        r.item_key = key;
        r.item_value = value;
        r.range_low = lo;
        r.range_high = hi;
        return r;
    endfunction

    function automatic void expect_rsp(logic ok, logic [KEY_BITS-1:0] key,
                                       logic [VALUE_BITS-1:0] value, logic last);
        rsp_t e;
        e.ok = ok;
        e.out_key = key;
        e.out_value = value;
        e.last = last;
        expected_rsp_q.push_back(e);
    endfunction

    function automatic void predict_request(req_t r);
        int pos;
        int hits;
        bit found;
        rsp_t tail;
        pos = 0;
        hits = 0;
        found = 1'b0;
        case (r.command)
            CMD_ENQ:
            begin
                while (pos < store_count && !found && store_key[pos] >= r.item_key)
                begin
                    if (store_key[pos] == r.item_key)
                        found = 1'b1;
                    else
                        pos++;
                end
                if (found)
                begin
                    store_val[pos] = r.item_value;
                    key_updates++;
                    expect_rsp(1'b1, r.item_key, r.item_value, 1'b1);
                end
                else if (store_count >= QUEUE_DEPTH)
                begin
                    full_rejects++;
                    expect_rsp(1'b0, r.item_key, r.item_value, 1'b1);
                end
                else
                begin
                    for (int i = store_count; i > pos; i--)
                    begin
                        store_key[i] = store_key[i-1];
                        store_val[i] = store_val[i-1];
                    end
                    store_key[pos] = r.item_key;
                    store_val[pos] = r.item_value;
                    store_count++;
                    expect_rsp(1'b1, r.item_key, r.item_value, 1'b1);
                end
            end
            CMD_DEQ:
            begin
                if (store_count == 0)
                    expect_rsp(1'b0, '0, '0, 1'b1);
                else
                begin
                    expect_rsp(1'b1, store_key[0], store_val[0], 1'b1);
                    for (int i = 1; i < store_count; i++)
                    begin
                        store_key[i-1] = store_key[i];
                        store_val[i-1] = store_val[i];
                    end
                    store_count--;
                end
            end
            CMD_RANGE:
            begin
                for (int i = 0; i < store_count; i++)
                begin
                    if (store_key[i] >= r.range_low && store_key[i] <= r.range_high)
                    begin
                        expect_rsp(1'b1, store_key[i], store_val[i], 1'b0);
                        hits++;
                    end
                end
                if (hits == 0)
                    expect_rsp(1'b0, '0, '0, 1'b1);
                else
                begin
                    tail = expected_rsp_q.pop_back();
                    tail.last = 1'b1;
                    expected_rsp_q.push_back(tail);
                end
                if (hits > longest_range)
                    longest_range = hits;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic req_t random_request();
        req_t r;
        int roll;
        int a;
        int b;
        r = make_req(CMD_IGNORE, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        roll = $urandom_range(99);
        if (roll < 5)
            return r;
        if (roll < 45)
        begin
            r.command = CMD_ENQ;
            roll = $urandom_range(99);
            if (store_count > 0 && roll < 35)
                r.item_key = store_key[$urandom_range(store_count - 1)];
            else if (roll < 45)
                r.item_key = $urandom_range(1) ? KEY_MAX - $urandom_range(1) : $urandom_range(1);
        end
        else if (roll < 72)
            r.command = CMD_DEQ;
        else
        begin
            r.command = CMD_RANGE;
            roll = $urandom_range(99);
            if (store_count > 0 && roll < 50)
            begin
                a = $urandom_range(store_count - 1);
                b = $urandom_range(store_count - 1);
                r.range_low = store_key[(a > b) ? a : b];
                r.range_high = store_key[(a > b) ? b : a];
            end
            else if (roll < 65)
            begin
                r.range_low = '0;
                r.range_high = KEY_MAX;
            end
        end
        return r;
    endfunction

    task automatic send_request(req_t r);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_request(r);
        requests_sent++;
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_store();
        send_request(make_req(CMD_DEQ, $urandom, {$urandom, $urandom}, $urandom, $urandom));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom}, '0, KEY_MAX));
        send_request(make_req(CMD_IGNORE, KEY_MAX, VALUE_MAX, KEY_MAX, KEY_MAX));
        wait_for_responses();
    endtask

    task automatic test_field_extremes();
        send_request(make_req(CMD_ENQ, '0, '0, '0, '0));
        send_request(make_req(CMD_ENQ, KEY_MAX, VALUE_MAX, KEY_MAX, KEY_MAX));
        send_request(make_req(CMD_ENQ, 32'h8000_0000, 64'h5555_5555_aaaa_aaaa, '0, '0));
        send_request(make_req(CMD_ENQ, KEY_MAX, '0, $urandom, $urandom));
        send_request(make_req(CMD_ENQ, '0, VALUE_MAX, $urandom, $urandom));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom}, '0, KEY_MAX));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom}, KEY_MAX, KEY_MAX));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom}, 32'h1, 32'h7fff_ffff));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom}, KEY_MAX, '0));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom}, '0, '0));
        send_request(make_req(CMD_IGNORE, KEY_MAX, VALUE_MAX, KEY_MAX, KEY_MAX));
        repeat (4)
            send_request(make_req(CMD_DEQ, $urandom, {$urandom, $urandom}, $urandom, $urandom));
        wait_for_responses();
    endtask

    task automatic test_fill_under_backpressure();
        hold_trigger++;
        while (store_count < QUEUE_DEPTH)
            send_request(make_req(CMD_ENQ, $urandom, {$urandom, $urandom}, $urandom, $urandom));
        repeat (2)
            send_request(make_req(CMD_ENQ, $urandom, {$urandom, $urandom}, $urandom, $urandom));
        send_request(make_req(CMD_ENQ, store_key[3], {$urandom, $urandom}, $urandom, $urandom));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom}, '0, KEY_MAX));
        send_request(make_req(CMD_DEQ, $urandom, {$urandom, $urandom}, $urandom, $urandom));
        send_request(make_req(CMD_RANGE, $urandom, {$urandom, $urandom},
                              store_key[10], store_key[2]));
        wait_for_responses();
    endtask

    task automatic test_random_traffic(int count, int idle_pct);
        req_t r;
        int sent;
        sent = 0;
        req_idle_pct = idle_pct;
        rsp_stall_pct = idle_pct;
        while (sent < count)
        begin
            r = random_request();
            send_request(r);
            if (r.command != CMD_IGNORE)
                sent++;
        end
        wait_for_responses();
        req_idle_pct = 27;
        rsp_stall_pct = 27;
    endtask

    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_responses
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("ok", want.ok, rsp.ok);
                check_field("out_key", want.out_key, rsp.out_key);
                check_field("out_value", want.out_value, rsp.out_value);
                check_field("last", want.last, rsp.last);
                responses_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_keyed_priority_queue_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_field_extremes();
        test_fill_under_backpressure();
        test_random_traffic(20, 27);
        test_random_traffic(40, 0);
        repeat (2 * QUEUE_DEPTH + 8)
            @(posedge clk);
        if (expected_rsp_q.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
        end
        $display("Sent %0d requests and checked %0d responses.", requests_sent,
                 responses_checked);
        $display("Saw %0d key updates, %0d rejects on a full store, ranges up to %0d entries.",
                 key_updates, full_rejects, longest_range);
        if (mismatches == 0)
            $display("tb_keyed_priority_queue_unit OK");
        else
            $display("tb_keyed_priority_queue_unit NOT OK");
        $finish;
    end

endmodule
